@@ src/tcw_pkg.sv @@
// tcw_pkg: shared constants, action codes and cursor control structs
// for the text console writer; no dependencies
`timescale 1ns / 1ps

package tcw_pkg;

  // item field widths
  localparam int ACT_W      = 2;
  localparam int CHAR_W     = 8;
  localparam int ATTR_W     = 8;
  localparam int IDX_W      = 11;
  localparam int ROW_OUT_W  = 5;
  localparam int COL_OUT_W  = 7;
  localparam int CELL_W     = CHAR_W + ATTR_W;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  // action codes
  localparam logic [ACT_W-1:0] ACT_PUT   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0a;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;

  // cursor commands from the sequencer
  typedef struct packed {
    logic advance;
    logic newline;
    logic home;
  } cur_cmd_t;

  // cursor position flags back to the sequencer
  typedef struct packed {
    logic last_row;
    logic last_col;
  } cur_stat_t;

endpackage

@@ src/text_console_writer.sv @@
// text_console_writer: text console engine over a ROWS x COLUMNS cell memory
// put, newline, read and unused codes: S_RESP loads the result once the output register is free
// scroll: S_COPY moves rows up, S_FILL blanks the bottom row; clear: S_CLEAR blanks all cells
// one item in flight; a new item is taken while the previous result waits
// after reset a clearing pass writes every cell with in_tready low; config writes are taken
// throughout. depends on tcw_pkg, tcw_cursor
`timescale 1ns / 1ps

module text_console_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [ATTR_W-1:0]     cfg_data,    // text_attribute
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,    // action, char_code, cell_index
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata    // pos_row, pos_col, cell_char, cell_attr
);

  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int CNT_W      = $clog2(CELL_COUNT + 1);
  localparam int ROW_W      = $clog2(ROWS);
  localparam int COL_W      = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int IDX_XW     = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;
  localparam int ROW_XW     = (ROW_W > ROW_OUT_W) ? ROW_W : ROW_OUT_W;
  localparam int COL_XW     = (COL_W > COL_OUT_W) ? COL_W : COL_OUT_W;
  localparam int PAD_W      = OUT_DATA_W - ROW_OUT_W - COL_OUT_W - CELL_W;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_RESP, S_COPY, S_FILL, S_CLEAR
  } state_t;

  state_t              state_r;
  logic [CNT_W-1:0]    ptr_r;
  logic                cp_pend_r;
  logic [ADDR_W-1:0]   cp_dst_r;
  logic [ACT_W-1:0]    act_r;
  logic                rd_ok_r;
  logic [ATTR_W-1:0]   attr_r;
  logic                out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic [CELL_W-1:0]   cells [CELL_COUNT];
  logic [CELL_W-1:0]   rd_data_r;

  logic                we;
  logic [ADDR_W-1:0]   waddr;
  logic [CELL_W-1:0]   wdata;
  logic                re;
  logic [ADDR_W-1:0]   raddr;

  cur_cmd_t            cmd;
  cur_stat_t           cur_stat;
  logic [ROW_W-1:0]    cur_row;
  logic [COL_W-1:0]    cur_col;
  logic [ADDR_W-1:0]   cur_addr;

  logic                accept;
  logic [ACT_W-1:0]    in_act;
  logic [CHAR_W-1:0]   in_code;
  logic [IDX_XW-1:0]   idx_wide;
  logic                scroll_go;
  logic                copy_issue;
  logic                ptr_last;
  logic [ROW_XW-1:0]   row_wide;
  logic [COL_XW-1:0]   col_wide;
  logic [CELL_W-1:0]   cell_out;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign in_act   = in_tdata[1:0];
  assign in_code  = in_tdata[9:2];
  assign idx_wide = IDX_XW'(in_tdata[20:10]);

  assign scroll_go = accept && (in_act == ACT_PUT) && cur_stat.last_row &&
                     ((in_code == NEWLINE_CODE) || cur_stat.last_col);
  assign copy_issue = (ptr_r != CNT_W'(CELL_COUNT));
  assign ptr_last   = (ptr_r == CNT_W'(CELL_COUNT - 1));

  assign row_wide = ROW_XW'(cur_row);
  assign col_wide = COL_XW'(cur_col);
  assign cell_out = ((act_r == ACT_READ) && rd_ok_r) ? rd_data_r : '0;

  tcw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .ROW_W   (ROW_W),
    .COL_W   (COL_W),
    .ADDR_W  (ADDR_W)
  ) u_cursor (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .row   (cur_row),
    .col   (cur_col),
    .addr  (cur_addr),
    .stat  (cur_stat)
  );

  // memory port control
  always_comb begin
    cmd   = '0;
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    re    = 1'b0;
    raddr = '0;
    unique case (state_r)
      S_INIT: begin
        we    = 1'b1;
        waddr = ptr_r[ADDR_W-1:0];
        wdata = {RESET_ATTR, SPACE_CODE};
      end
      S_IDLE: begin
        if (accept) begin
          case (in_act)
            ACT_PUT: begin
              if (in_code == NEWLINE_CODE) begin
                cmd.newline = 1'b1;
              end else begin
                we          = 1'b1;
                waddr       = cur_addr;
                wdata       = {attr_r, in_code};
                cmd.advance = 1'b1;
              end
            end
            ACT_CLEAR: cmd.home = 1'b1;
            ACT_READ: begin
              re    = 1'b1;
              raddr = idx_wide[ADDR_W-1:0];
            end
            default: ;
          endcase
        end
      end
      S_COPY: begin
        // read row below, write it one row up in the following cycle
        if (copy_issue) begin
          re    = 1'b1;
          raddr = ptr_r[ADDR_W-1:0];
        end
        if (cp_pend_r) begin
          we    = 1'b1;
          waddr = cp_dst_r;
          wdata = rd_data_r;
        end
      end
      S_FILL, S_CLEAR: begin
        we    = 1'b1;
        waddr = ptr_r[ADDR_W-1:0];
        wdata = {attr_r, SPACE_CODE};
      end
      S_RESP: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      cells[waddr] <= wdata;
    end
    if (re) begin
      rd_data_r <= cells[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      ptr_r       <= '0;
      cp_pend_r   <= 1'b0;
      attr_r      <= RESET_ATTR;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        attr_r <= cfg_data;
      end
      // in S_RESP the output register is handled below
      if (out_valid_r && out_tready && (state_r != S_RESP)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_INIT: begin
          ptr_r <= ptr_r + 1'b1;
          if (ptr_last) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            act_r   <= in_act;
            rd_ok_r <= (idx_wide < IDX_XW'(CELL_COUNT));
            if (scroll_go) begin
              state_r   <= S_COPY;
              ptr_r     <= CNT_W'(COLUMNS);
              cp_pend_r <= 1'b0;
            end else if (in_act == ACT_CLEAR) begin
              state_r <= S_CLEAR;
              ptr_r   <= '0;
            end else begin
              state_r <= S_RESP;
            end
          end
        end
        S_COPY: begin
          cp_pend_r <= copy_issue;
          if (copy_issue) begin
            ptr_r    <= ptr_r + 1'b1;
            cp_dst_r <= ADDR_W'(ptr_r - CNT_W'(COLUMNS));
          end else begin
            state_r <= S_FILL;
            ptr_r   <= CNT_W'(CELL_COUNT - COLUMNS);
          end
        end
        S_FILL, S_CLEAR: begin
          ptr_r <= ptr_r + 1'b1;
          if (ptr_last) begin
            state_r <= S_RESP;
          end
        end
        S_RESP: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {PAD_W'(0), cell_out, col_wide[COL_OUT_W-1:0],
                            row_wide[ROW_OUT_W-1:0]};
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ src/tcw_cursor.sv @@
// tcw_cursor: cursor row/column registers plus the running cell address
// of the cursor; depends on tcw_pkg
`timescale 1ns / 1ps

module tcw_cursor
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  parameter int ROW_W   = 5,
  parameter int COL_W   = 7,
  parameter int ADDR_W  = 11
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cur_cmd_t          cmd,
  output logic [ROW_W-1:0]  row,
  output logic [COL_W-1:0]  col,
  output logic [ADDR_W-1:0] addr,
  output cur_stat_t         stat
);

  logic [ROW_W-1:0]  row_r;
  logic [COL_W-1:0]  col_r;
  logic [ADDR_W-1:0] base_r;   // row_r * COLUMNS, kept incrementally
  logic              wrap;

  assign stat.last_row = (row_r == ROW_W'(ROWS - 1));
  assign stat.last_col = (col_r == COL_W'(COLUMNS - 1));
  assign row  = row_r;
  assign col  = col_r;
  assign addr = base_r + ADDR_W'(col_r);

  assign wrap = cmd.newline || (cmd.advance && stat.last_col);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      base_r <= '0;
    end else if (cmd.home) begin
      row_r  <= '0;
      col_r  <= '0;
      base_r <= '0;
    end else if (wrap) begin
      col_r <= '0;
      // on the last row the scroll keeps the cursor on the bottom row
      if (!stat.last_row) begin
        row_r  <= row_r + 1'b1;
        base_r <= base_r + ADDR_W'(COLUMNS);
      end
    end else if (cmd.advance) begin
      col_r <= col_r + 1'b1;
    end
  end

endmodule

@@ sim/tb_text_console_writer.sv @@
// tb_text_console_writer: self-checking bench for the text console writer,
// keeps its own copy of the screen and cursor and checks every result.
// depends on tcw_pkg and the text_console_writer rtl
`timescale 1ns / 1ps

module tb_text_console_writer;
  import tcw_pkg::*;

  localparam int SCR_COLS   = 80;
  localparam int SCR_ROWS   = 25;
  localparam int SCR_CELLS  = SCR_COLS * SCR_ROWS;
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam int PHASE_COUNT = 6;
  localparam int PHASE_ITEMS = 275;

  typedef struct packed {
    logic [ATTR_W-1:0]    attr;
    logic [CHAR_W-1:0]    ch;
    logic [COL_OUT_W-1:0] col;
    logic [ROW_OUT_W-1:0] row;
  } console_status_t;

  // shadow of the screen and cursor, plus the results still owed by the block
  class console_mirror;
    logic [CELL_W-1:0] cells [SCR_CELLS];
    int                row_pos;
    int                col_pos;
    logic [ATTR_W-1:0] attr;
    console_status_t   owed_status [$];
    int                errors;

    function new();
      attr = RESET_ATTR;
      foreach (cells[i]) cells[i] = {RESET_ATTR, SPACE_CODE};
      row_pos = 0;
      col_pos = 0;
      errors  = 0;
    endfunction

    function void set_attr(logic [ATTR_W-1:0] v);
      attr = v;
    endfunction

    function void next_row();
      col_pos = 0;
      row_pos++;
      if (row_pos >= SCR_ROWS) begin
        for (int i = 0; i + SCR_COLS < SCR_CELLS; i++) cells[i] = cells[i + SCR_COLS];
        for (int i = SCR_CELLS - SCR_COLS; i < SCR_CELLS; i++) cells[i] = {attr, SPACE_CODE};
        row_pos = SCR_ROWS - 1;
      end
    endfunction

    function void accept_item(logic [ACT_W-1:0] act, logic [CHAR_W-1:0] ch,
                              logic [IDX_W-1:0] idx);
      console_status_t st;
      st = '0;
      case (act)
        ACT_PUT: begin
          if (ch == NEWLINE_CODE) begin
            next_row();
          end else begin
            cells[row_pos * SCR_COLS + col_pos] = {attr, ch};
            col_pos++;
            if (col_pos >= SCR_COLS) next_row();
          end
        end
        ACT_CLEAR: begin
          foreach (cells[i]) cells[i] = {attr, SPACE_CODE};
          row_pos = 0;
          col_pos = 0;
        end
        ACT_READ: begin
          if (idx < SCR_CELLS) {st.attr, st.ch} = cells[idx];
        end
        default: ;
      endcase
      st.row = row_pos[ROW_OUT_W-1:0];
      st.col = col_pos[COL_OUT_W-1:0];
      owed_status.push_back(st);
    endfunction

    function void check_status(logic [OUT_DATA_W-1:0] data);
      console_status_t got, want;
      got = data[$bits(console_status_t)-1:0];
      if (owed_status.size() == 0) begin
        $error("result with no item outstanding: %h", data);
        errors++;
        return;
      end
      want = owed_status.pop_front();
      if (got.row != want.row) begin
        $error("pos_row: expected %0d, got %0d", want.row, got.row);
        errors++;
      end
      if (got.col != want.col) begin
        $error("pos_col: expected %0d, got %0d", want.col, got.col);
        errors++;
      end
      if (got.ch != want.ch) begin
        $error("cell_char: expected %h, got %h", want.ch, got.ch);
        errors++;
      end
      if (got.attr != want.attr) begin
        $error("cell_attr: expected %h, got %h", want.attr, got.attr);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [ATTR_W-1:0]     cfg_data;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;    // action, char_code, cell_index
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;   // pos_row, pos_col, cell_char, cell_attr

  console_mirror mirror;
  bit            in_gaps_on;
  bit            out_stalls_on;
  int            items_sent;

  always #5 clk = ~clk;

  text_console_writer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // transfers seen at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        mirror.accept_item(in_tdata[1:0], in_tdata[9:2], in_tdata[20:10]);
      if (out_tvalid && out_tready)
        mirror.check_status(out_tdata);
    end
  end

  // result side back-pressure
  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = out_stalls_on ? $urandom_range(0, 19) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  task automatic send_item(input logic [ACT_W-1:0] act, input logic [CHAR_W-1:0] ch,
                           input logic [IDX_W-1:0] idx);
    int gap;
    gap = in_gaps_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W - IDX_W - CHAR_W - ACT_W){1'b0}}, idx, ch, act};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    if (act != ACT_UNUSED) items_sent++;
  endtask

  // lower valid and hold off until every owed result is back
  task automatic drain();
    in_tvalid <= 1'b0;
    while (mirror.owed_status.size() != 0) @(negedge clk);
  endtask

  task automatic write_attr(input logic [ATTR_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    mirror.set_attr(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_sequence();
    int kind, len, cursor_idx;
    logic [CHAR_W-1:0] ch;
    kind = $urandom_range(0, 99);
    in_gaps_on    = ($urandom_range(0, 3) != 0);
    out_stalls_on = ($urandom_range(0, 3) != 0);
    if (kind < 42) begin
      // run of up to 120 characters, so lines can wrap
      len = $urandom_range(1, 120);
      repeat (len) begin
        ch = ($urandom_range(0, 15) == 0) ? NEWLINE_CODE : CHAR_W'($urandom_range(0, 255));
        send_item(ACT_PUT, ch, IDX_W'($urandom_range(0, 2047)));
      end
    end else if (kind < 47) begin
      // run of newlines, scrolls once the cursor hits the bottom
      len = $urandom_range(1, 30);
      repeat (len) send_item(ACT_PUT, NEWLINE_CODE, IDX_W'($urandom_range(0, 2047)));
    end else if (kind < 84) begin
      len = $urandom_range(1, 8);
      repeat (len) begin
        cursor_idx = mirror.row_pos * SCR_COLS + mirror.col_pos;
        case ($urandom_range(0, 5))
          0:       cursor_idx = $urandom_range(SCR_CELLS, 2047);
          1, 2:    cursor_idx = (cursor_idx > 3) ? cursor_idx - $urandom_range(1, 3) : 0;
          3:       cursor_idx = $urandom_range(SCR_CELLS - SCR_COLS, SCR_CELLS - 1);
          default: cursor_idx = $urandom_range(0, SCR_CELLS - 1);
        endcase
        send_item(ACT_READ, CHAR_W'($urandom_range(0, 255)), IDX_W'(cursor_idx));
      end
    end else if (kind < 88) begin
      send_item(ACT_CLEAR, CHAR_W'($urandom_range(0, 255)), IDX_W'($urandom_range(0, 2047)));
    end else begin
      len = $urandom_range(1, 3);
      repeat (len)
        send_item(ACT_UNUSED, CHAR_W'($urandom_range(0, 255)),
                  IDX_W'($urandom_range(0, 2047)));
    end
  endtask

  initial begin
    int phase_end;
    mirror        = new();
    rst_n         = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b0;
    items_sent    = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    // the block clears its memory before taking items
    do @(posedge clk); while (!in_tready);
    @(negedge clk);

    // directed checks with the reset attribute
    send_item(ACT_READ, 8'h00, 11'd0);
    send_item(ACT_READ, 8'hff, 11'd1999);
    send_item(ACT_READ, 8'h00, 11'd2000);
    send_item(ACT_READ, 8'h00, 11'h7ff);
    send_item(ACT_UNUSED, 8'hff, 11'h7ff);
    send_item(ACT_PUT, 8'h00, 11'h7ff);
    send_item(ACT_PUT, 8'hff, 11'd0);
    send_item(ACT_PUT, 8'h41, 11'd0);
    send_item(ACT_READ, 8'h00, 11'd0);
    send_item(ACT_READ, 8'h00, 11'd1);
    send_item(ACT_READ, 8'h00, 11'd2);
    send_item(ACT_PUT, NEWLINE_CODE, 11'd0);
    send_item(ACT_READ, 8'h00, 11'd80);
    send_item(ACT_PUT, 8'h42, 11'd0);
    send_item(ACT_READ, 8'h00, 11'd80);
    send_item(ACT_CLEAR, 8'hff, 11'h7ff);
    send_item(ACT_READ, 8'h00, 11'd1);
    send_item(ACT_PUT, 8'h55, 11'h7ff);
    send_item(ACT_READ, 8'h00, 11'd0);

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      if (phase > 0) begin
        drain();
        case (phase)
          1:       write_attr(8'hff);
          2:       write_attr(8'h00);
          5:       write_attr(RESET_ATTR);
          default: write_attr(ATTR_W'($urandom_range(0, 255)));
        endcase
      end
      phase_end = (phase + 1) * PHASE_ITEMS;
      while (items_sent < phase_end) random_sequence();
    end

    drain();
    repeat (50) @(negedge clk);
    if (mirror.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // hang guard: far beyond a run where every item is a clear
  initial begin
    #200ms;
    $display("FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
src/tcw_pkg.sv
src/tcw_cursor.sv
src/text_console_writer.sv
sim/tb_text_console_writer.sv
